// ===== rtl/huffman_byte_encoder_defines.svh =====
// Assertion macros shared by the encoder checker.
// No dependencies.
`ifndef HUFFMAN_BYTE_ENCODER_DEFINES_SVH
`define HUFFMAN_BYTE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbe assertion failed");

// Next-cycle implication, disabled during reset.
`define HBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbe assertion failed");

`endif

// ===== rtl/hbe_pkg.sv =====
// Shared constants, opcodes and structs of the Huffman byte encoder.
// No dependencies.
package hbe_pkg;

    localparam int SYMBOL_COUNT  = 256;
    localparam int MAX_CODE_BITS = 32;
    localparam int SYM_W         = 8;
    localparam int CODE_W        = 32;
    localparam int LEN_W         = 6;
    localparam int TOTAL_W       = 48;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = $clog2(BYTE_W + 1);
    localparam int ACC_W         = BYTE_W + CODE_W;
    localparam int SYM_IDX_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_opcode;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_bk_state;

    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_stat;

endpackage

// ===== rtl/huffman_byte_encoder.sv =====
// Huffman byte encoder: with the queue empty, a flush passes the front-end stage register, the
// command queue and the output register; an encode that completes a byte also passes the work
// accumulator before the output register; loads give none. The packer takes a flush or a byteless
// encode in its idle state and emits an encode's bytes one per cycle while the output is not stalled.
// Synchronous active-low reset clears the queue, accumulator, bit total and output.
// Depends on hbe_pkg, hbe_front, hbe_cmd_fifo and hbe_back.
module huffman_byte_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // symbol[7:0], code_bits[39:8], bit_len[45:40], zero
    input  logic [1:0]  i_s_tuser,  // opcode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,  // out_byte[7:0], total_bits[55:8]
    output logic [1:0]  o_m_tuser,  // byte_present[0], is_flush[1]
    output logic        o_m_tlast
);
    import hbe_pkg::*;

    t_fifo_stat         stat;
    t_cmd               push_cmd;
    t_cmd               head_cmd;
    logic               push;
    logic               pop;
    logic [BYTE_W-1:0]  out_byte;
    logic [TOTAL_W-1:0] out_total;
    logic               out_present;
    logic               out_flush;

    hbe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_opcode    (i_s_tuser),
        .i_symbol    (i_s_tdata[SYM_W-1:0]),
        .i_code_bits (i_s_tdata[SYM_W+CODE_W-1:SYM_W]),
        .i_bit_len   (i_s_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W]),
        .i_stat      (stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    hbe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (stat)
    );

    hbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stat    (stat),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (out_byte),
        .o_present (out_present),
        .o_flush   (out_flush),
        .o_total   (out_total),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {out_total, out_byte};
    assign o_m_tuser = {out_flush, out_present};

endmodule

// ===== rtl/hbe_front.sv =====
// Front end: accepts items, holds the code table, issues encode and flush commands.
// Depends on hbe_pkg.
module hbe_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [hbe_pkg::SYM_W-1:0] i_symbol,
    input  logic [hbe_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hbe_pkg::LEN_W-1:0] i_bit_len,
    input  hbe_pkg::t_fifo_stat       i_stat,
    output logic                      o_push,
    output hbe_pkg::t_cmd             o_cmd
);
    import hbe_pkg::*;

    logic [CODE_W+LEN_W-1:0] r_mem [SYMBOL_COUNT];
    logic [CODE_W+LEN_W-1:0] r_rd;
    logic                    r_stg_valid;
    logic                    r_stg_flush;
    logic                    r_stg_inrange;
    logic [FIFO_CNT_W:0]     used;
    logic                    accept;
    logic                    inrange;
    logic [SYM_IDX_W-1:0]    idx;
    logic [LEN_W-1:0]        len_sat;
    logic                    is_load;
    logic                    is_cmd;

    assign used    = {1'b0, i_stat.count} + {{FIFO_CNT_W{1'b0}}, r_stg_valid};
    assign o_ready = used < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign accept  = i_valid && o_ready;
    assign inrange = {1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign idx     = i_symbol[SYM_IDX_W-1:0];
    assign len_sat = ({1'b0, i_bit_len} > (LEN_W + 1)'(MAX_CODE_BITS))
                   ? LEN_W'(MAX_CODE_BITS) : i_bit_len;

    always_comb begin
        is_load = 1'b0;
        is_cmd  = 1'b0;
        case (i_opcode)
            OP_LOAD:   is_load = 1'b1;
            OP_ENCODE: is_cmd  = 1'b1;
            OP_FLUSH:  is_cmd  = 1'b1;
            default:   is_cmd  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_load && inrange) begin
            r_mem[idx] <= {i_code_bits, len_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd          <= r_mem[idx];
            r_stg_flush   <= (i_opcode == OP_FLUSH);
            r_stg_inrange <= inrange;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else begin
            r_stg_valid <= accept && is_cmd;
        end
    end

    assign o_push      = r_stg_valid;
    assign o_cmd.flush = r_stg_flush;
    assign o_cmd.code  = r_rd[CODE_W+LEN_W-1:LEN_W];
    assign o_cmd.len   = r_stg_inrange ? r_rd[LEN_W-1:0] : '0;

endmodule

// ===== rtl/hbe_cmd_fifo.sv =====
// Command queue between the front end and the bit packer.
// Depends on hbe_pkg.
module hbe_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hbe_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output hbe_pkg::t_cmd       o_head,
    output hbe_pkg::t_fifo_stat o_stat
);
    import hbe_pkg::*;

    t_cmd                  r_q [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= FIFO_PTR_W'((FIFO_PTR_W + 1)'(r_wp) + 1'b1);
            end
            if (i_pop) begin
                r_rp <= FIFO_PTR_W'((FIFO_PTR_W + 1)'(r_rp) + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_q[r_rp];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

// ===== rtl/hbe_back.sv =====
// Back end: bit accumulator, byte packer, bit total and output register.
// Depends on hbe_pkg.
module hbe_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hbe_pkg::t_fifo_stat          i_stat,
    input  hbe_pkg::t_cmd                i_cmd,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hbe_pkg::BYTE_W-1:0]   o_byte,
    output logic                         o_present,
    output logic                         o_flush,
    output logic [hbe_pkg::TOTAL_W-1:0]  o_total,
    output logic                         o_last
);
    import hbe_pkg::*;

    t_bk_state          r_state, n_state;
    logic [BYTE_W-1:0]  r_pend, n_pend;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [ACC_W-1:0]   r_work, n_work;
    logic [LEN_W-1:0]   r_wcnt, n_wcnt;
    logic               r_ov, n_ov;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic               r_present, n_present;
    logic               r_flush, n_flush;
    logic [TOTAL_W-1:0] r_otot, n_otot;
    logic               r_last, n_last;

    logic                  out_free;
    logic [2*CODE_W-1:0]   code_sh;
    logic [ACC_W-1:0]      work_new;
    logic [LEN_W-1:0]      t_new;
    logic [TOTAL_W:0]      sum;
    logic [TOTAL_W-1:0]    total_new;
    logic [LEN_W-1:0]      rem;
    logic                  emit_done;

    assign out_free  = !r_ov || i_ready;
    assign code_sh   = {i_cmd.code, {CODE_W{1'b0}}} >> i_cmd.len;
    assign work_new  = {r_pend, {CODE_W{1'b0}}}
                     | ({code_sh[CODE_W-1:0], {BYTE_W{1'b0}}} >> r_cnt);
    assign t_new     = {{(LEN_W-CNT_W){1'b0}}, r_cnt} + i_cmd.len;
    assign sum       = {1'b0, r_total} + {{(TOTAL_W+1-LEN_W){1'b0}}, i_cmd.len};
    assign total_new = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    assign rem       = r_wcnt - LEN_W'(BYTE_W);
    assign emit_done = rem <= LEN_W'(BYTE_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_pend  <= '0;
            r_cnt   <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work    <= n_work;
        r_wcnt    <= n_wcnt;
        r_byte    <= n_byte;
        r_present <= n_present;
        r_flush   <= n_flush;
        r_otot    <= n_otot;
        r_last    <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_total   = r_total;
        n_work    = r_work;
        n_wcnt    = r_wcnt;
        n_ov      = r_ov && !i_ready;
        n_byte    = r_byte;
        n_present = r_present;
        n_flush   = r_flush;
        n_otot    = r_otot;
        n_last    = r_last;
        o_pop     = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_stat.empty) begin
                    if (i_cmd.flush) begin
                        if (out_free) begin
                            o_pop     = 1'b1;
                            n_ov      = 1'b1;
                            n_byte    = r_pend;
                            n_present = (r_cnt != '0);
                            n_flush   = 1'b1;
                            n_otot    = r_total;
                            n_last    = 1'b1;
                            n_pend    = '0;
                            n_cnt     = '0;
                            n_total   = '0;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_total = total_new;
                        if (t_new > LEN_W'(BYTE_W)) begin
                            n_work  = work_new;
                            n_wcnt  = t_new;
                            n_state = BK_EMIT;
                        end else begin
                            n_pend = work_new[ACC_W-1:CODE_W];
                            n_cnt  = t_new[CNT_W-1:0];
                        end
                    end
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_byte    = r_work[ACC_W-1:CODE_W];
                    n_present = 1'b1;
                    n_flush   = 1'b0;
                    n_otot    = '0;
                    n_last    = emit_done;
                    n_work    = r_work << BYTE_W;
                    n_wcnt    = rem;
                    if (emit_done) begin
                        n_pend  = r_work[CODE_W-1:CODE_W-BYTE_W];
                        n_cnt   = rem[CNT_W-1:0];
                        n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_valid   = r_ov;
    assign o_byte    = r_byte;
    assign o_present = r_present;
    assign o_flush   = r_flush;
    assign o_total   = r_otot;
    assign o_last    = r_last;

endmodule

// ===== rtl/hbe_checker.sv =====
// Port-level checks of the Huffman byte encoder, bound to the top level.
// Depends on hbe_pkg and huffman_byte_encoder_defines.svh.
`include "huffman_byte_encoder_defines.svh"
module hbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] i_m_tdata,
    input logic [1:0]  i_m_tuser,
    input logic        i_m_tlast
);
    import hbe_pkg::*;

    `HBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))
    `HBE_ASSERT_NOW(a_flush_last, i_clk, i_rst_n, i_m_tvalid && i_m_tuser[1], i_m_tlast)
    `HBE_ASSERT_NOW(a_encode_fields, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser[1], i_m_tuser[0] && (i_m_tdata[55:8] == '0))
    `HBE_ASSERT_NOW(a_empty_flush, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser[0], i_m_tuser[1] && (i_m_tdata[7:0] == '0))

endmodule

bind huffman_byte_encoder hbe_checker u_hbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

// ===== bench/tb.sv =====
// Stream testbench for huffman_byte_encoder: queued loads, encodes and flushes
// go through randomized handshakes and are checked against an in-bench predictor.
// Depends on hbe_pkg and the huffman_byte_encoder RTL.
`timescale 1ns / 100ps

module tb;
    import hbe_pkg::*;

    localparam logic [1:0]         OP_UNUSED = 2'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam int                 MAX_SHOWN = 10;
    localparam int                 HOLD_LEN  = 120;

    typedef struct packed {
        logic [1:0]        op;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_enc_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               present;
        logic               flush;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_enc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid = 1'b0;
    logic        o_s_tready;
    logic [47:0] s_data = '0;   // symbol[7:0], code_bits[39:8], bit_len[45:40], zero
    logic [1:0]  s_user = '0;   // opcode[1:0]
    logic        o_m_tvalid;
    logic        m_ready = 1'b0;
    logic [55:0] o_m_tdata;     // out_byte[7:0], total_bits[55:8]
    logic [1:0]  o_m_tuser;     // byte_present[0], is_flush[1]
    logic        o_m_tlast;

    huffman_byte_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    t_enc_item   pending_items[$];
    t_enc_result expected_bytes[$];
    t_enc_item   offered_item;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          mismatches = 0;
    logic        hold_arm = 1'b0;
    int          hold_state = 0;
    int          hold_left = 0;

    // generator's view of which table entries are loaded
    logic [SYM_W-1:0] loaded_syms[$];
    bit               loaded_mask[SYMBOL_COUNT];

    // predictor state
    logic [CODE_W-1:0]  enc_code_tab[SYMBOL_COUNT];
    logic [LEN_W-1:0]   enc_len_tab[SYMBOL_COUNT];
    logic [BYTE_W:0]    enc_acc = '0;
    int                 enc_acc_cnt = 0;
    logic [TOTAL_W-1:0] enc_bit_total = '0;

    task automatic predict_encoder(input t_enc_item it);
        logic [CODE_W-1:0] code;
        int                len;
        int                n;
        logic [BYTE_W:0]   aligned;
        n = 0;
        case (it.op)
            OP_LOAD: begin
                enc_code_tab[it.sym] = it.code;
                enc_len_tab[it.sym]  = (it.len > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS) : it.len;
            end
            OP_ENCODE: begin
                code = enc_code_tab[it.sym];
                len  = enc_len_tab[it.sym];
                if (TOTAL_MAX - enc_bit_total < len)
                    enc_bit_total = TOTAL_MAX;
                else
                    enc_bit_total = enc_bit_total + len;
                for (int i = len; i > 0; i--) begin
                    enc_acc = {enc_acc[BYTE_W-1:0], code[i-1]};
                    enc_acc_cnt++;
                    if (enc_acc_cnt == BYTE_W + 1) begin
                        expected_bytes.push_back('{enc_acc[BYTE_W:1], 1'b1, 1'b0, '0, 1'b0});
                        n++;
                        enc_acc     = {{BYTE_W{1'b0}}, enc_acc[0]};
                        enc_acc_cnt = 1;
                    end
                end
                if (n > 0)
                    expected_bytes[expected_bytes.size()-1].last = 1'b1;
            end
            OP_FLUSH: begin
                if (enc_acc_cnt == 0) begin
                    expected_bytes.push_back('{'0, 1'b0, 1'b1, enc_bit_total, 1'b1});
                end else begin
                    aligned = enc_acc << (BYTE_W - enc_acc_cnt);
                    expected_bytes.push_back('{aligned[BYTE_W-1:0], 1'b1, 1'b1,
                                               enc_bit_total, 1'b1});
                end
                enc_acc       = '0;
                enc_acc_cnt   = 0;
                enc_bit_total = '0;
            end
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready)
                predict_encoder(offered_item);
            if (!s_valid || o_s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= {2'b00, offered_item.len, offered_item.code, offered_item.sym};
                    s_user  <= offered_item.op;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_state == 1) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
            if (hold_left == 0)
                hold_state = 2;
        end else if (hold_arm && hold_state == 0) begin
            m_ready <= 1'b0;
            hold_left  = HOLD_LEN;
            hold_state = 1;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_enc_result got;
        t_enc_result want;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            got = '{o_m_tdata[7:0], o_m_tuser[0], o_m_tuser[1], o_m_tdata[55:8], o_m_tlast};
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected transaction: byte %h present %b flush %b total %0d last %b",
                             got.out_byte, got.present, got.flush, got.total, got.last);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: exp byte %h present %b flush %b total %0d last %b, got byte %h present %b flush %b total %0d last %b",
                                 want.out_byte, want.present, want.flush, want.total, want.last,
                                 got.out_byte, got.present, got.flush, got.total, got.last);
                end
            end
        end
    end

    function automatic void push_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                      input logic [CODE_W-1:0] code,
                                      input logic [LEN_W-1:0] len);
        pending_items.push_back('{op, sym, code, len});
        if (op == OP_LOAD && !loaded_mask[sym]) begin
            loaded_mask[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endfunction

    // returns 0 for an item the block ignores
    function automatic int push_random_item();
        int               pick;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(99) < 70)
                len = LEN_W'($urandom_range(10, 1));
            else if ($urandom_range(1))
                len = LEN_W'($urandom_range(MAX_CODE_BITS));
            else
                len = LEN_W'($urandom_range(63));
            push_item(OP_LOAD, SYM_W'($urandom_range(255)), $urandom, len);
        end else if (pick < 85) begin
            push_item(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                      $urandom, LEN_W'($urandom));
        end else if (pick < 95) begin
            push_item(OP_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        end else begin
            push_item(OP_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            return 0;
        end
        return 1;
    endfunction

    task automatic set_idle(input int src_pct, input int snk_pct);
        @(negedge i_clk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    task automatic run_random(input int count);
        int done;
        done = 0;
        @(negedge i_clk);
        while (done < count)
            done += push_random_item();
        while (pending_items.size() != 0 || s_valid)
            @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idle(0, 0);
        push_item(OP_FLUSH,  8'd0,   32'h0,        6'd0);
        push_item(OP_LOAD,   8'd0,   32'h0,        6'd0);
        push_item(OP_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32);
        push_item(OP_LOAD,   8'd1,   32'hAAAA_AAAA, 6'd63);
        push_item(OP_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd3);
        push_item(OP_LOAD,   8'd3,   32'h0,        6'd1);
        push_item(OP_LOAD,   8'd128, 32'h8000_0001, 6'd32);
        push_item(OP_ENCODE, 8'd0,   32'h0,        6'd0);
        push_item(OP_FLUSH,  8'd0,   32'h0,        6'd0);
        push_item(OP_ENCODE, 8'd2,   32'h0,        6'd0);
        push_item(OP_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'd63);
        push_item(OP_ENCODE, 8'd255, 32'h0,        6'd0);
        push_item(OP_ENCODE, 8'd255, 32'h0,        6'd0);
        push_item(OP_FLUSH,  8'd0,   32'h0,        6'd0);
        push_item(OP_UNUSED, 8'hFF,  32'hFFFF_FFFF, 6'h3F);
        push_item(OP_ENCODE, 8'd1,   32'h0,        6'd0);
        push_item(OP_ENCODE, 8'd3,   32'h0,        6'd0);
        push_item(OP_ENCODE, 8'd128, 32'h0,        6'd0);
        push_item(OP_FLUSH,  8'd0,   32'h0,        6'd0);
        push_item(OP_LOAD,   8'd2,   32'h0000_0005, 6'd33);
        push_item(OP_ENCODE, 8'd2,   32'h0,        6'd0);
        push_item(OP_ENCODE, 8'd3,   32'h0,        6'd0);
        push_item(OP_FLUSH,  8'd0,   32'h0,        6'd0);
        while (pending_items.size() != 0 || s_valid)
            @(negedge i_clk);

        run_random(20);
        set_idle(65, 0);
        run_random(20);
        set_idle(0, 65);
        run_random(20);
        set_idle(6, 6);
        run_random(20);

        set_idle(0, 0);
        hold_arm = 1'b1;
        run_random(25);
        while (hold_state != 2)
            @(negedge i_clk);

        set_idle(0, 0);
        while (expected_bytes.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
